FILE: rtl/core/priority_counting_semaphore_core_defines.svh
// Assertion macros shared by the semaphore core RTL.
`ifndef PRIORITY_COUNTING_SEMAPHORE_CORE_DEFINES_SVH
`define PRIORITY_COUNTING_SEMAPHORE_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define PCS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define PCS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pcs_pkg.sv
// Shared types and codes for the priority counting semaphore core.
`timescale 1ns / 1ps

package pcs_pkg;

  localparam int MAX_WAITERS_DEF = 16;

  // Request codes
  localparam logic [1:0] OP_WAIT    = 2'd0;
  localparam logic [1:0] OP_TRYWAIT = 2'd1;
  localparam logic [1:0] OP_POST    = 2'd2;
  localparam logic [1:0] OP_INIT    = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_ACQUIRED = 3'd0;
  localparam logic [2:0] ST_QUEUED   = 3'd1;
  localparam logic [2:0] ST_BLOCKED  = 3'd2;
  localparam logic [2:0] ST_TRYFAIL  = 3'd3;
  localparam logic [2:0] ST_BANKED   = 3'd4;
  localparam logic [2:0] ST_HANDED   = 3'd5;
  localparam logic [2:0] ST_INIT     = 3'd6;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam logic REG_START_COUNT = 1'b0;

  // One waiter table entry
  typedef struct packed {
    logic [7:0] prio;
    logic [7:0] id;
  } entry_t;

  // Control for the shared priority compare unit
  typedef struct packed {
    logic en;
    logic first;
  } cmp_ctl_t;

endpackage

FILE: rtl/core/priority_counting_semaphore_core.sv
// Priority counting semaphore: request sequencer, count and waiter bookkeeping.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | request: op, caller_valid, id, priority
//  m_*      | out | m_tvalid/m_tready  | result: status, woken, id, count, waiters
//  apb      | in  | psel/penable/pready| start count register at address 0
//
// Wait, trywait, init and a post with no waiters finish in the accept cycle; the
// result is in the output register in the next cycle. A post with n waiters then
// takes n table reads, a final compare and the slot move after the accept cycle:
// the single table read port feeds one priority compare per cycle. Reset clears
// control state only; table contents stay undefined until written. A finished
// result holds in the output register; the next request is taken once the
// sequencer is idle and that register is empty or transferring in the same cycle.
`timescale 1ns / 1ps

`include "priority_counting_semaphore_core_defines.svh"

module priority_counting_semaphore_core
  import pcs_pkg::*;
#(
  parameter int MAX_WAITERS = MAX_WAITERS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // request stream
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [15:0]        s_tdata,   // [7:0] caller_id, [15:8] caller_priority
  input  logic [2:0]         s_tuser,   // [1:0] op, [2] caller_valid
  // result stream
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [31:0]        m_tdata,   // [7:0] woken_id, [23:8] count_now,
                                        // [28:24] waiters_now, [31:29] zero
  output logic [3:0]         m_tuser,   // [2:0] status, [3] woken_valid
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IDX_W = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int TOT_W = $clog2(MAX_WAITERS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_LAST = 2'd2;
  localparam logic [1:0] S_MOVE = 2'd3;

  // Control and state registers
  logic [15:0]      start_count;
  logic [15:0]      sem_count;
  logic [15:0]      sem_count_next;
  logic [TOT_W-1:0] total;
  logic [TOT_W-1:0] total_next;
  logic [1:0]       state;
  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] cmp_idx;
  logic             cmp_pend;
  entry_t           last_entry;

  // Result register
  logic [2:0]  o_status;
  logic        o_woken_valid;
  logic [7:0]  o_woken_id;
  logic [15:0] o_count;
  logic [4:0]  o_waiters;

  // Request fields
  logic [1:0] op;
  logic       caller_valid;
  entry_t     caller_entry;

  logic             accept;
  logic             cfg_wr;
  logic             post_scan;
  logic             simple_done;
  logic [2:0]       status_next;
  logic [IDX_W-1:0] last_idx;

  // Table and compare unit signals
  logic             tbl_wr_en;
  logic [IDX_W-1:0] tbl_wr_addr;
  entry_t           tbl_wr_data;
  logic             tbl_rd_en;
  entry_t           tbl_rd_data;
  cmp_ctl_t         cmp_ctl;
  entry_t           best_entry;
  logic [IDX_W-1:0] best_idx;

  assign op                = s_tuser[1:0];
  assign caller_valid      = s_tuser[2];
  assign caller_entry.id   = s_tdata[7:0];
  assign caller_entry.prio = s_tdata[15:8];

  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign last_idx = IDX_W'(total - TOT_W'(1));

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_START_COUNT);
  assign prdata = (paddr[2] == REG_START_COUNT) ? {16'd0, start_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_count <= 16'd0;
    end else if (cfg_wr) begin
      start_count <= pwdata[15:0];
    end
  end

  // Decide each request: count, waiter total, status and whether a post scans
  always_comb begin
    sem_count_next = sem_count;
    total_next     = total;
    status_next    = ST_BLOCKED;
    post_scan      = 1'b0;
    case (op)
      OP_WAIT: begin
        if (sem_count != 16'd0) begin
          sem_count_next = sem_count - 16'd1;
          status_next    = ST_ACQUIRED;
        end else if (caller_valid && (total < TOT_W'(MAX_WAITERS))) begin
          total_next  = total + TOT_W'(1);
          status_next = ST_QUEUED;
        end else begin
          status_next = ST_BLOCKED;
        end
      end
      OP_TRYWAIT: begin
        if (sem_count != 16'd0) begin
          sem_count_next = sem_count - 16'd1;
          status_next    = ST_ACQUIRED;
        end else begin
          status_next = ST_TRYFAIL;
        end
      end
      OP_POST: begin
        if (total == TOT_W'(0)) begin
          if (sem_count != COUNT_MAX) begin
            sem_count_next = sem_count + 16'd1;
          end
          status_next = ST_BANKED;
        end else begin
          post_scan   = 1'b1;
          status_next = ST_HANDED;
        end
      end
      default: begin
        sem_count_next = start_count;
        total_next     = TOT_W'(0);
        status_next    = ST_INIT;
      end
    endcase
  end

  assign simple_done = accept && !post_scan;

  // Table write: enqueue on a queued wait, refill the vacated slot on handoff
  always_comb begin
    tbl_wr_en   = 1'b0;
    tbl_wr_addr = IDX_W'(total);
    tbl_wr_data = caller_entry;
    if (state == S_MOVE) begin
      tbl_wr_en   = 1'b1;
      tbl_wr_addr = best_idx;
      tbl_wr_data = last_entry;
    end else if (simple_done && (status_next == ST_QUEUED)) begin
      tbl_wr_en = 1'b1;
    end
  end

  assign tbl_rd_en     = (state == S_SCAN);
  assign cmp_ctl.en    = cmp_pend && ((state == S_SCAN) || (state == S_LAST));
  assign cmp_ctl.first = (cmp_idx == IDX_W'(0));

  pcs_table #(
    .DEPTH (MAX_WAITERS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_en   (tbl_rd_en),
    .rd_addr (scan_idx),
    .rd_data (tbl_rd_data)
  );

  pcs_best #(
    .IDX_W (IDX_W)
  ) u_best (
    .clk        (clk),
    .ctl        (cmp_ctl),
    .entry      (tbl_rd_data),
    .idx        (cmp_idx),
    .best_entry (best_entry),
    .best_idx   (best_idx)
  );

  // Sequencer: scan all waiters, then move the last entry into the winner's slot
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sem_count <= 16'd0;
      total     <= TOT_W'(0);
      cmp_pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            sem_count <= sem_count_next;
            total     <= total_next;
            if (post_scan) begin
              state    <= S_SCAN;
              scan_idx <= IDX_W'(0);
              cmp_pend <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          cmp_pend <= 1'b1;
          cmp_idx  <= scan_idx;
          scan_idx <= scan_idx + IDX_W'(1);
          if (scan_idx == last_idx) begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          last_entry <= tbl_rd_data;
          cmp_pend   <= 1'b0;
          state      <= S_MOVE;
        end
        S_MOVE: begin
          total <= total - TOT_W'(1);
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result register: load on completion, drop after transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (simple_done || (state == S_MOVE)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_MOVE) begin
      o_status      <= ST_HANDED;
      o_woken_valid <= 1'b1;
      o_woken_id    <= best_entry.id;
      o_count       <= sem_count;
      o_waiters     <= 5'(total - TOT_W'(1));
    end else if (simple_done) begin
      o_status      <= status_next;
      o_woken_valid <= 1'b0;
      o_woken_id    <= 8'd0;
      o_count       <= sem_count_next;
      o_waiters     <= 5'(total_next);
    end
  end

  assign m_tdata = {3'd0, o_waiters, o_count, o_woken_id};
  assign m_tuser = {o_woken_valid, o_status};

  // Checks
  `PCS_ASSERT_SAME(a_total_bound, clk, rst, 1'b1, total <= TOT_W'(MAX_WAITERS), "waiter total above table depth")
  `PCS_ASSERT_SAME(a_woken_handed, clk, rst, m_tvalid && m_tuser[3], m_tuser[2:0] == ST_HANDED, "woken flag without handoff status")
  `PCS_ASSERT_NEXT(a_post_scans, clk, rst, accept && (op == OP_POST) && (total != TOT_W'(0)), state == S_SCAN, "post with waiters did not start a scan")
  `PCS_ASSERT_NEXT(a_move_result, clk, rst, state == S_MOVE, m_tvalid && (state == S_IDLE), "handoff finished without a result")

endmodule

FILE: rtl/core/pcs_table.sv
// Waiter table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module pcs_table
  import pcs_pkg::*;
#(
  parameter int DEPTH = MAX_WAITERS_DEF,
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one entry, data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/pcs_best.sv
// Shared priority compare unit: keeps the best entry seen during a scan.
`timescale 1ns / 1ps

module pcs_best
  import pcs_pkg::*;
#(
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  cmp_ctl_t         ctl,
  input  entry_t           entry,
  input  logic [IDX_W-1:0] idx,
  output entry_t           best_entry,
  output logic [IDX_W-1:0] best_idx
);

  logic take;

  // Take the first entry, then only a strictly higher priority (ties keep lower slot)
  assign take = ctl.en && (ctl.first || (entry.prio > best_entry.prio));

  always_ff @(posedge clk) begin
    if (take) begin
      best_entry <= entry;
      best_idx   <= idx;
    end
  end

endmodule
